[hdl/sfd_pkg.sv]
// shared constants and types for the sync-word frame deframer
package sfd_pkg;

    localparam logic [7:0] SYNC_A  = 8'h5A;
    localparam logic [7:0] SYNC_B  = 8'hA5;
    localparam int         HDR_LEN = 10;

    localparam int OFF_LEN_LO = 2;
    localparam int OFF_LEN_HI = 3;
    localparam int OFF_ID_LO  = 6;
    localparam int OFF_ID_HI  = 7;
    localparam int OFF_CHK_LO = 8;
    localparam int OFF_CHK_HI = 9;

    typedef struct packed {
        logic wr;
        logic drop;
    } win_cmd_t;

endpackage

[hdl/sync_frame_deframer_checksum.sv]
// top level of the sync-word frame deframer with 16-bit sum checksum
//
//   channel | dir | tdata fields (low bit up)                           | tlast
//   s_      | in  | rx_byte[7:0]                                        | -
//   m_      | out | frame_byte[7:0], byte_index[13:8], dest_id[29:14]   | last
//
// each received byte is stored in S_IDLE and judged in S_HUNT, then every window byte
// is fetched in S_RD and used in S_USE through the single memory read port while hunting
// (header fields, then each payload byte through the shared adder)
// an accepted frame then emits each byte through S_RD and S_USE, waiting while m_tready is low
// s_tready is high only while the sequencer is idle
// reset clears the window pointers and fill count; unwritten window bytes never reach m_
module sync_frame_deframer_checksum import sfd_pkg::*; #(
    parameter int MAX_FRAME = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // frame_byte, byte_index, dest_id, zero pad
    output logic        m_tlast
);

    localparam int FW = $clog2(MAX_FRAME + 1);
    localparam int OW = $clog2(MAX_FRAME + 2);

    win_cmd_t      cmd;
    logic [OW-1:0] rd_off;
    logic [OW-1:0] drop_n;
    logic [7:0]    rd_data;
    logic [FW-1:0] fill;
    logic [7:0]    out_byte;
    logic [5:0]    out_index;
    logic [15:0]   out_id;

    sfd_window #(
        .MAX_FRAME (MAX_FRAME)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .wr_data (s_tdata),
        .rd_off  (rd_off),
        .drop_n  (drop_n),
        .rd_data (rd_data),
        .fill    (fill)
    );

    sfd_seq #(
        .MAX_FRAME (MAX_FRAME)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_byte  (out_byte),
        .out_index (out_index),
        .out_id    (out_id),
        .out_last  (m_tlast),
        .cmd       (cmd),
        .rd_off    (rd_off),
        .drop_n    (drop_n),
        .rd_data   (rd_data),
        .fill      (fill)
    );

    assign m_tdata = {2'b00, out_id, out_index, out_byte};

endmodule

[hdl/sfd_window.sv]
// circular byte window: storage, start pointer, fill count and address wrap
module sfd_window import sfd_pkg::*; #(
    parameter int MAX_FRAME = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  win_cmd_t                            cmd,
    input  logic [7:0]                          wr_data,
    input  logic [$clog2(MAX_FRAME+2)-1:0]      rd_off,
    input  logic [$clog2(MAX_FRAME+2)-1:0]      drop_n,
    output logic [7:0]                          rd_data,
    output logic [$clog2(MAX_FRAME+1)-1:0]      fill
);

    localparam int AW = $clog2(MAX_FRAME);
    localparam int FW = $clog2(MAX_FRAME + 1);
    localparam int OW = $clog2(MAX_FRAME + 2);
    localparam int SW = OW + 1;
    localparam logic [SW-1:0] DEPTH = SW'(MAX_FRAME);

    logic [7:0]    mem [MAX_FRAME];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] start_reg, start_next;
    logic [FW-1:0] fill_reg, fill_next;

    logic [SW-1:0] rd_sum, wr_sum, drop_sum, one_sum;
    logic [AW-1:0] rd_idx, wr_idx, drop_idx, one_idx;

    assign rd_sum   = SW'(start_reg) + SW'(rd_off);
    assign wr_sum   = SW'(start_reg) + SW'(fill_reg);
    assign drop_sum = SW'(start_reg) + SW'(drop_n);
    assign one_sum  = SW'(start_reg) + SW'(1);

    assign rd_idx   = (rd_sum   >= DEPTH) ? AW'(rd_sum   - DEPTH) : AW'(rd_sum);
    assign wr_idx   = (wr_sum   >= DEPTH) ? AW'(wr_sum   - DEPTH) : AW'(wr_sum);
    assign drop_idx = (drop_sum >= DEPTH) ? AW'(drop_sum - DEPTH) : AW'(drop_sum);
    assign one_idx  = (one_sum  >= DEPTH) ? AW'(one_sum  - DEPTH) : AW'(one_sum);

    always_comb begin
        start_next = start_reg;
        fill_next  = fill_reg;
        if (cmd.wr) begin
            if (fill_reg == FW'(MAX_FRAME)) begin
                // full: oldest byte gives way
                start_next = one_idx;
            end else begin
                fill_next = fill_reg + FW'(1);
            end
        end else if (cmd.drop) begin
            start_next = drop_idx;
            fill_next  = fill_reg - FW'(drop_n);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            fill_reg  <= '0;
        end else begin
            start_reg <= start_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    assign rd_data = rd_data_reg;
    assign fill    = fill_reg;

endmodule

[hdl/sfd_seq.sv]
// hunt sequencer with shared checksum adder and output register
module sfd_seq import sfd_pkg::*; #(
    parameter int MAX_FRAME = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [7:0]                          out_byte,
    output logic [5:0]                          out_index,
    output logic [15:0]                         out_id,
    output logic                                out_last,
    output win_cmd_t                            cmd,
    output logic [$clog2(MAX_FRAME+2)-1:0]      rd_off,
    output logic [$clog2(MAX_FRAME+2)-1:0]      drop_n,
    input  logic [7:0]                          rd_data,
    input  logic [$clog2(MAX_FRAME+1)-1:0]      fill
);

    localparam int OW = $clog2(MAX_FRAME + 2);
    localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME - HDR_LEN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HUNT,
        S_RD,
        S_USE,
        S_CMP
    } state_t;

    typedef enum logic [3:0] {
        P_SYNC0,
        P_SYNC1,
        P_LEN0,
        P_LEN1,
        P_CHK0,
        P_CHK1,
        P_ID0,
        P_ID1,
        P_SUM,
        P_EMIT
    } phase_t;

    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [OW-1:0] off_reg, off_next;
    logic [OW-1:0] len_reg, len_next;
    logic [7:0]    len_lo_reg, len_lo_next;
    logic [15:0]   chk_reg, chk_next;
    logic [15:0]   id_reg, id_next;
    logic [15:0]   sum_reg, sum_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic [5:0]    out_index_reg, out_index_next;
    logic [15:0]   out_id_reg, out_id_next;
    logic          out_last_reg, out_last_next;

    logic [15:0]   len_full;
    logic [OW-1:0] frame_len, emit_len, fill_ext;
    logic [15:0]   addend;
    logic          out_free;

    assign len_full  = {rd_data, len_lo_reg};
    assign frame_len = len_reg + OW'(HDR_LEN);
    assign emit_len  = frame_len + OW'(len_reg[0]);
    assign fill_ext  = OW'(fill);
    assign addend    = off_reg[0] ? {rd_data, 8'h00} : {8'h00, rd_data};
    assign out_free  = !out_valid_reg || out_ready;

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        len_lo_next    = len_lo_reg;
        chk_next       = chk_reg;
        id_next        = id_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_index_next = out_index_reg;
        out_id_next    = out_id_reg;
        out_last_next  = out_last_reg;
        cmd            = '0;
        drop_n         = OW'(1);

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.wr     = 1'b1;
                    state_next = S_HUNT;
                end
            end
            S_HUNT: begin
                if (fill_ext < OW'(HDR_LEN)) begin
                    state_next = S_IDLE;
                end else begin
                    off_next   = '0;
                    phase_next = P_SYNC0;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_USE;
            end
            S_USE: begin
                case (phase_reg)
                    P_SYNC0: begin
                        if (rd_data != SYNC_A) begin
                            cmd.drop   = 1'b1;
                            state_next = S_HUNT;
                        end else begin
                            off_next   = OW'(1);
                            phase_next = P_SYNC1;
                            state_next = S_RD;
                        end
                    end
                    P_SYNC1: begin
                        if (rd_data != SYNC_B) begin
                            cmd.drop   = 1'b1;
                            drop_n     = OW'(2);
                            state_next = S_HUNT;
                        end else begin
                            off_next   = OW'(OFF_LEN_LO);
                            phase_next = P_LEN0;
                            state_next = S_RD;
                        end
                    end
                    P_LEN0: begin
                        len_lo_next = rd_data;
                        off_next    = OW'(OFF_LEN_HI);
                        phase_next  = P_LEN1;
                        state_next  = S_RD;
                    end
                    P_LEN1: begin
                        if (len_full > MAX_LEN) begin
                            cmd.drop   = 1'b1;
                            drop_n     = OW'(2);
                            state_next = S_HUNT;
                        end else if (fill_ext < OW'(len_full) + OW'(HDR_LEN)) begin
                            state_next = S_IDLE;
                        end else begin
                            len_next   = OW'(len_full);
                            off_next   = OW'(OFF_CHK_LO);
                            phase_next = P_CHK0;
                            state_next = S_RD;
                        end
                    end
                    P_CHK0: begin
                        chk_next[7:0] = rd_data;
                        off_next      = OW'(OFF_CHK_HI);
                        phase_next    = P_CHK1;
                        state_next    = S_RD;
                    end
                    P_CHK1: begin
                        chk_next[15:8] = rd_data;
                        off_next       = OW'(OFF_ID_LO);
                        phase_next     = P_ID0;
                        state_next     = S_RD;
                    end
                    P_ID0: begin
                        id_next[7:0] = rd_data;
                        off_next     = OW'(OFF_ID_HI);
                        phase_next   = P_ID1;
                        state_next   = S_RD;
                    end
                    P_ID1: begin
                        id_next[15:8] = rd_data;
                        sum_next      = '0;
                        if (len_reg == '0) begin
                            state_next = S_CMP;
                        end else begin
                            off_next   = OW'(HDR_LEN);
                            phase_next = P_SUM;
                            state_next = S_RD;
                        end
                    end
                    P_SUM: begin
                        sum_next = sum_reg + addend;
                        if (off_reg == frame_len - OW'(1)) begin
                            state_next = S_CMP;
                        end else begin
                            off_next   = off_reg + OW'(1);
                            state_next = S_RD;
                        end
                    end
                    P_EMIT: begin
                        if (out_free) begin
                            out_valid_next = 1'b1;
                            out_byte_next  = (off_reg < frame_len) ? rd_data : 8'h00;
                            out_index_next = off_reg[5:0];
                            out_id_next    = id_reg;
                            out_last_next  = (off_reg == emit_len - OW'(1));
                            if (off_reg == emit_len - OW'(1)) begin
                                cmd.drop   = 1'b1;
                                drop_n     = frame_len;
                                state_next = S_IDLE;
                            end else begin
                                off_next   = off_reg + OW'(1);
                                state_next = S_RD;
                            end
                        end
                    end
                    default: begin
                        state_next = S_HUNT;
                    end
                endcase
            end
            S_CMP: begin
                if (sum_reg != chk_reg) begin
                    cmd.drop   = 1'b1;
                    drop_n     = OW'(2);
                    state_next = S_HUNT;
                end else begin
                    off_next   = '0;
                    phase_next = P_EMIT;
                    state_next = S_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            phase_reg     <= P_SYNC0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
        off_reg       <= off_next;
        len_reg       <= len_next;
        len_lo_reg    <= len_lo_next;
        chk_reg       <= chk_next;
        id_reg        <= id_next;
        sum_reg       <= sum_next;
        out_byte_reg  <= out_byte_next;
        out_index_reg <= out_index_next;
        out_id_reg    <= out_id_next;
        out_last_reg  <= out_last_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign rd_off    = off_reg;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_index = out_index_reg;
    assign out_id    = out_id_reg;
    assign out_last  = out_last_reg;

endmodule

[bench/sfd_frame_checker.sv]
// frame checker: predicts emitted frame bytes from received bytes and compares them
`timescale 1ns / 100ps
module sfd_frame_checker import sfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // frame_byte, byte_index, dest_id, zero pad
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding,
    output int          bytes_in,
    output int          frames_out,
    output int          bytes_out
);

    localparam int WIN = 64;

    typedef struct packed {
        logic [7:0]  fbyte;
        logic [5:0]  pos;
        logic [15:0] tid;
        logic        last;
    } out_rec_t;

    logic [7:0] win_bytes [WIN];
    int         win_head;
    int         win_count;
    out_rec_t   frame_q [$];

    function automatic logic [7:0] held(input int off);
        return win_bytes[(win_head + off) % WIN];
    endfunction

    function automatic void drop_bytes(input int n);
        if (n > win_count) begin
            n = win_count;
        end
        win_head  = (win_head + n) % WIN;
        win_count = win_count - n;
    endfunction

    // store one received byte and hunt for at most one complete frame
    task automatic absorb_byte(input logic [7:0] b);
        int          len, flen, elen, k;
        logic [15:0] sum, chk, tid;
        bit          done;
        out_rec_t    rec;
        if (win_count >= WIN) begin
            drop_bytes(1);
        end
        win_bytes[(win_head + win_count) % WIN] = b;
        win_count++;
        done = 1'b0;
        while (!done && win_count >= HDR_LEN) begin
            if (held(0) != SYNC_A) begin
                drop_bytes(1);
            end else if (held(1) != SYNC_B) begin
                drop_bytes(2);
            end else begin
                len = {held(OFF_LEN_HI), held(OFF_LEN_LO)};
                flen = len + HDR_LEN;
                if (len > WIN - HDR_LEN) begin
                    drop_bytes(2);
                end else if (win_count < flen) begin
                    done = 1'b1;
                end else begin
                    sum = 16'h0000;
                    for (k = 0; k < len; k += 2) begin
                        sum = sum + {((k + 1 < len) ? held(HDR_LEN + k + 1) : 8'h00),
                                     held(HDR_LEN + k)};
                    end
                    chk = {held(OFF_CHK_HI), held(OFF_CHK_LO)};
                    if (sum != chk) begin
                        drop_bytes(2);
                    end else begin
                        tid  = {held(OFF_ID_HI), held(OFF_ID_LO)};
                        elen = flen + (len & 1);
                        for (k = 0; k < elen; k++) begin
                            rec.fbyte = (k < flen) ? held(k) : 8'h00;
                            rec.pos   = 6'(k);
                            rec.tid   = tid;
                            rec.last  = (k == elen - 1);
                            frame_q.push_back(rec);
                        end
                        drop_bytes(flen);
                        frames_out++;
                        done = 1'b1;
                    end
                end
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        out_rec_t want;
        if (!aresetn) begin
            win_head   = 0;
            win_count  = 0;
            frame_q    = {};
            mismatches = 0;
            bytes_in   = 0;
            frames_out = 0;
            bytes_out  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                bytes_out++;
                if (frame_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected frame byte %02h index %0d, nothing outstanding",
                                 $realtime, m_tdata[7:0], m_tdata[13:8]);
                    end
                    mismatches++;
                end else begin
                    want = frame_q.pop_front();
                    if (m_tdata[7:0] !== want.fbyte || m_tdata[13:8] !== want.pos ||
                        m_tdata[29:14] !== want.tid || m_tlast !== want.last) begin
                        if (mismatches < 10) begin
                            $display("%0t: expected byte %02h idx %0d id %04h last %0b, got %02h %0d %04h %0b",
                                     $realtime, want.fbyte, want.pos, want.tid, want.last,
                                     m_tdata[7:0], m_tdata[13:8], m_tdata[29:14], m_tlast);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                bytes_in++;
                absorb_byte(s_tdata);
            end
        end
        outstanding <= frame_q.size();
    end

endmodule

[bench/sync_frame_deframer_checksum_test.sv]
// testbench top: byte stimulus, output back-pressure and verdict for the deframer
`timescale 1ns / 100ps
module sync_frame_deframer_checksum_test import sfd_pkg::*;;

    localparam int HOLD_CYCLES = 700;
    localparam int N_ITEMS     = 460;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire [31:0]  m_tdata;
    wire         m_tlast;

    int mismatches, outstanding, bytes_in, frames_out, bytes_out;
    int sent_n  = 0;
    bit hold_go = 1'b0;
    bit calm_tx = 1'b0;

    sync_frame_deframer_checksum #(.MAX_FRAME(64)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sfd_frame_checker u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .bytes_in    (bytes_in),
        .frames_out  (frames_out),
        .bytes_out   (bytes_out)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("FAIL sync_frame_deframer_checksum");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        while (!calm_tx && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sent_n++;
        if (sent_n == 120) begin
            hold_go = 1'b1;
        end
    endtask

    task automatic send_frame(input int len, input logic [15:0] tid, input bit corrupt);
        logic [7:0]  pay [$];
        logic [15:0] sum;
        int          k;
        pay = {};
        sum = 16'h0000;
        for (k = 0; k < len; k++) begin
            pay.push_back(8'($urandom_range(255)));
        end
        for (k = 0; k < len; k += 2) begin
            sum = sum + {((k + 1 < len) ? pay[k + 1] : 8'h00), pay[k]};
        end
        if (corrupt) begin
            sum = sum ^ 16'(1 << $urandom_range(15));
        end
        push_byte(SYNC_A);
        push_byte(SYNC_B);
        push_byte(8'(len));
        push_byte(8'(len >> 8));
        push_byte(8'($urandom_range(255)));
        push_byte(8'($urandom_range(255)));
        push_byte(tid[7:0]);
        push_byte(tid[15:8]);
        push_byte(sum[7:0]);
        push_byte(sum[15:8]);
        for (k = 0; k < len; k++) begin
            push_byte(pay[k]);
        end
    endtask

    // receiver: random stalls, one long hold-off, then a calm stretch, then random stalls again
    initial begin
        int cyc;
        cyc = 0;
        forever begin
            @(posedge aclk);
            if (hold_go && cyc < HOLD_CYCLES) begin
                m_tready <= 1'b0;
                cyc++;
            end else if (hold_go && cyc < HOLD_CYCLES + 1500) begin
                m_tready <= 1'b1;
                cyc++;
            end else begin
                m_tready <= ($urandom_range(99) >= 13);
            end
        end
    end

    initial begin
        int          pick, len;
        bit          paused;
        logic [7:0]  b;
        paused = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // bad first sync byte, bad second sync byte, empty frame, odd frame with pad
        push_byte(8'h00);
        push_byte(SYNC_A);
        push_byte(8'h33);
        send_frame(0, 16'hFFFF, 1'b0);
        send_frame(1, 16'h0000, 1'b0);

        // largest frames and an oversize length
        send_frame(54, 16'($urandom_range(65535)), 1'b0);
        send_frame(53, 16'($urandom_range(65535)), 1'b0);
        push_byte(SYNC_A);
        push_byte(SYNC_B);
        push_byte(8'hFF);
        push_byte(8'hFF);

        while (sent_n < N_ITEMS) begin
            calm_tx = (sent_n >= 180 && sent_n < 260);
            if (!paused && sent_n >= 320) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (outstanding != 0) @(posedge aclk);
            end
            pick = $urandom_range(99);
            if (pick < 62) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 54) : $urandom_range(0, 12);
                send_frame(len, 16'($urandom_range(65535)), 1'b0);
            end else if (pick < 72) begin
                send_frame($urandom_range(0, 16), 16'($urandom_range(65535)), 1'b1);
            end else if (pick < 80) begin
                len = $urandom_range(55, 65535);
                push_byte(SYNC_A);
                push_byte(SYNC_B);
                push_byte(8'(len));
                push_byte(8'(len >> 8));
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
            end else if (pick < 95) begin
                b = 8'($urandom_range(255));
                push_byte(SYNC_A);
                push_byte((b == SYNC_B) ? 8'h00 : b);
            end else begin
                push_byte(SYNC_A);
                push_byte(SYNC_B);
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
            end
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);

        $display("run covered %0d received bytes, %0d predicted frames, %0d frame bytes compared",
                 bytes_in, frames_out, bytes_out);
        $display("including a %0d-cycle output hold-off and a pause to drain all frames",
                 HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS sync_frame_deframer_checksum");
        end else begin
            $display("FAIL sync_frame_deframer_checksum");
        end
        $finish;
    end

endmodule
